// ----- hw/rtl/vector3_normalize_defines.svh -----
// assertion macros for the vector normaliser
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, held off during reset
`define V3N_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("vector3_normalize assertion failed");
// next-cycle implication, also checked in reset
`define V3N_ASSERT_NXT(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("vector3_normalize assertion failed");
`else
`define V3N_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define V3N_ASSERT_NXT(lbl, clk, a, c)
`endif
`endif

// ----- hw/rtl/v3n_pkg.sv -----
package v3n_pkg;
    // default component input width
    localparam int IN_WIDTH_DEF = 32;
    // default fraction bits of the normalised output
    localparam int OUT_FRAC_BITS_DEF = 16;
endpackage

// ----- hw/rtl/v3n_front.sv -----
module v3n_front #(
    parameter int IN_WIDTH = v3n_pkg::IN_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IN_WIDTH-1:0]   i_x,
    input  logic [IN_WIDTH-1:0]   i_y,
    input  logic [IN_WIDTH-1:0]   i_z,
    output logic                  o_valid,
    output logic [2*IN_WIDTH-1:0] o_sum,
    output logic [3*IN_WIDTH-1:0] o_mag,
    output logic [2:0]            o_neg
);
    localparam int W = IN_WIDTH;

    logic [2:0]       r_valid;
    logic [3*W-1:0]   r_mag1, r_mag2, r_mag3;
    logic [2:0]       r_neg1, r_neg2, r_neg3;
    logic [2*W-1:0]   r_sq [0:2];
    logic [2*W-1:0]   r_sum;
    logic [3*W-1:0]   n_mag;
    logic [2:0]       n_neg;
    logic [W-1:0]     s_raw [0:2];

    assign s_raw[0] = i_x;
    assign s_raw[1] = i_y;
    assign s_raw[2] = i_z;

    // magnitude and sign of each component
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = s_raw[i][W-1];
            n_mag[i*W +: W] = s_raw[i][W-1] ? (~s_raw[i] + 1'b1) : s_raw[i];
        end
    end

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // magnitudes, squares, then sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag1 <= n_mag;
            r_neg1 <= n_neg;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= {{W{1'b0}}, r_mag1[i*W +: W]} * {{W{1'b0}}, r_mag1[i*W +: W]};
            end
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
            r_sum  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_mag3 <= r_mag2;
            r_neg3 <= r_neg2;
        end
    end

    assign o_valid = r_valid[2];
    assign o_sum   = r_sum;
    assign o_mag   = r_mag3;
    assign o_neg   = r_neg3;
endmodule

// ----- hw/rtl/v3n_sqrt_cell.sv -----
module v3n_sqrt_cell #(
    parameter int IN_WIDTH = v3n_pkg::IN_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2*IN_WIDTH-1:0] i_rad,
    input  logic [IN_WIDTH+1:0]   i_rem,
    input  logic [IN_WIDTH-1:0]   i_root,
    input  logic [3*IN_WIDTH-1:0] i_mag,
    input  logic [2:0]            i_neg,
    output logic                  o_valid,
    output logic [2*IN_WIDTH-1:0] o_rad,
    output logic [IN_WIDTH+1:0]   o_rem,
    output logic [IN_WIDTH-1:0]   o_root,
    output logic [3*IN_WIDTH-1:0] o_mag,
    output logic [2:0]            o_neg
);
    localparam int W  = IN_WIDTH;
    localparam int RW = W + 2;

    logic            r_valid;
    logic [2*W-1:0]  r_rad;
    logic [RW-1:0]   r_rem;
    logic [W-1:0]    r_root;
    logic [3*W-1:0]  r_mag;
    logic [2:0]      r_neg;
    logic [RW+1:0]   s_cur;
    logic [RW+1:0]   s_trial;
    logic [RW+1:0]   s_diff;
    logic [RW-1:0]   n_rem;
    logic [W-1:0]    n_root;

    // one root bit from the next pair of radicand bits
    always_comb begin
        s_cur   = {i_rem, i_rad[2*W-1 -: 2]};
        s_trial = {2'b00, i_root, 2'b01};
        s_diff  = s_cur - s_trial;
        if (s_cur >= s_trial) begin
            n_rem  = s_diff[RW-1:0];
            n_root = {i_root[W-2:0], 1'b1};
        end else begin
            n_rem  = s_cur[RW-1:0];
            n_root = {i_root[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[2*W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_mag  <= i_mag;
            r_neg  <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;
endmodule

// ----- hw/rtl/v3n_div_cell.sv -----
module v3n_div_cell #(
    parameter int IN_WIDTH      = v3n_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = v3n_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [IN_WIDTH-1:0]          i_len,
    input  logic [3*IN_WIDTH-1:0]        i_rem,
    input  logic [2:0]                   i_bit,
    input  logic [3*(OUT_FRAC_BITS+1)-1:0] i_quo,
    input  logic [2:0]                   i_neg,
    input  logic                         i_zero,
    output logic                         o_valid,
    output logic [IN_WIDTH-1:0]          o_len,
    output logic [3*IN_WIDTH-1:0]        o_rem,
    output logic [3*(OUT_FRAC_BITS+1)-1:0] o_quo,
    output logic [2:0]                   o_neg,
    output logic                         o_zero
);
    localparam int W  = IN_WIDTH;
    localparam int QW = OUT_FRAC_BITS + 1;

    logic            r_valid;
    logic [W-1:0]    r_len;
    logic [3*W-1:0]  r_rem;
    logic [3*QW-1:0] r_quo;
    logic [2:0]      r_neg;
    logic            r_zero;
    logic [3*W-1:0]  n_rem;
    logic [3*QW-1:0] n_quo;
    logic [W:0]      s_cur  [0:2];
    logic [W:0]      s_diff [0:2];

    // one quotient bit per lane
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_cur[i]  = {i_rem[i*W +: W], i_bit[i]};
            s_diff[i] = s_cur[i] - {1'b0, i_len};
            if (s_cur[i] >= {1'b0, i_len}) begin
                n_rem[i*W +: W]   = s_diff[i][W-1:0];
                n_quo[i*QW +: QW] = {i_quo[i*QW +: QW-1], 1'b1};
            end else begin
                n_rem[i*W +: W]   = s_cur[i][W-1:0];
                n_quo[i*QW +: QW] = {i_quo[i*QW +: QW-1], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len  <= i_len;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_neg  <= i_neg;
            r_zero <= i_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_neg   = r_neg;
    assign o_zero  = r_zero;
endmodule

// ----- hw/rtl/vector3_normalize.sv -----
// Normalises a signed 3-component vector to unit length in signed Q1.OUT_FRAC_BITS.
// One vector is taken every cycle unless the output stalls; each result passes
// through the three front stages, one square-root cell per root bit and one
// divider cell per quotient bit. A stall on the output freezes the whole
// pipeline. A zero vector gives zero components with zero_length set.
`include "vector3_normalize_defines.svh"
module vector3_normalize #(
    parameter int IN_WIDTH      = v3n_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = v3n_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [IN_WIDTH-1:0]       i_in_x,
    input  logic [IN_WIDTH-1:0]       i_in_y,
    input  logic [IN_WIDTH-1:0]       i_in_z,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [OUT_FRAC_BITS+1:0]  o_out_x,
    output logic [OUT_FRAC_BITS+1:0]  o_out_y,
    output logic [OUT_FRAC_BITS+1:0]  o_out_z,
    output logic                      o_zero_length
);
    localparam int W  = IN_WIDTH;
    localparam int F  = OUT_FRAC_BITS;
    localparam int QW = F + 1;
    localparam int OW = F + 2;

    logic s_en;

    // sqrt chain signals
    logic            sq_valid [0:W];
    logic [2*W-1:0]  sq_rad   [0:W];
    logic [W+1:0]    sq_rem   [0:W];
    logic [W-1:0]    sq_root  [0:W];
    logic [3*W-1:0]  sq_mag   [0:W];
    logic [2:0]      sq_neg   [0:W];

    // divider chain signals
    logic            dv_valid [0:QW];
    logic [W-1:0]    dv_len   [0:QW];
    logic [3*W-1:0]  dv_rem   [0:QW];
    logic [2:0]      dv_bit   [0:QW-1];
    logic [3*QW-1:0] dv_quo   [0:QW];
    logic [2:0]      dv_neg   [0:QW];
    logic            dv_zero  [0:QW];

    logic [OW-1:0]   s_res [0:2];
    logic [QW-1:0]   s_q   [0:2];

    // global advance, held while a result waits
    assign s_en    = !(o_valid && i_stall);
    assign o_stall = !s_en;

    // magnitudes and sum of squares
    v3n_front #(.IN_WIDTH(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (i_valid),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_z     (i_in_z),
        .o_valid (sq_valid[0]),
        .o_sum   (sq_rad[0]),
        .o_mag   (sq_mag[0]),
        .o_neg   (sq_neg[0])
    );
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    // square root, one bit per cell
    for (genvar k = 0; k < W; k++) begin : g_sqrt
        v3n_sqrt_cell #(.IN_WIDTH(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_valid (sq_valid[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_mag   (sq_mag[k]),
            .i_neg   (sq_neg[k]),
            .o_valid (sq_valid[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_mag   (sq_mag[k+1]),
            .o_neg   (sq_neg[k+1])
        );
    end

    // divider entry: remainder is the magnitude less its low bit
    assign dv_valid[0] = sq_valid[W];
    assign dv_len[0]   = sq_root[W];
    assign dv_neg[0]   = sq_neg[W];
    assign dv_zero[0]  = (sq_root[W] == '0);
    assign dv_quo[0]   = '0;
    for (genvar i = 0; i < 3; i++) begin : g_entry
        assign dv_rem[0][i*W +: W] = {1'b0, sq_mag[W][i*W+1 +: W-1]};
        assign dv_bit[0][i]        = sq_mag[W][i*W];
    end
    for (genvar k = 1; k < QW; k++) begin : g_bit
        assign dv_bit[k] = 3'b000;
    end

    // long division, one quotient bit per cell
    for (genvar k = 0; k < QW; k++) begin : g_div
        v3n_div_cell #(.IN_WIDTH(W), .OUT_FRAC_BITS(F)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_valid (dv_valid[k]),
            .i_len   (dv_len[k]),
            .i_rem   (dv_rem[k]),
            .i_bit   (dv_bit[k]),
            .i_quo   (dv_quo[k]),
            .i_neg   (dv_neg[k]),
            .i_zero  (dv_zero[k]),
            .o_valid (dv_valid[k+1]),
            .o_len   (dv_len[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_quo   (dv_quo[k+1]),
            .o_neg   (dv_neg[k+1]),
            .o_zero  (dv_zero[k+1])
        );
    end

    // clamp to one, apply sign, zero vector override
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_q[i] = dv_quo[QW][i*QW +: QW];
            if (s_q[i] > {1'b1, {F{1'b0}}}) begin
                s_q[i] = {1'b1, {F{1'b0}}};
            end
            if (dv_zero[QW]) begin
                s_res[i] = '0;
            end else if (dv_neg[QW][i]) begin
                s_res[i] = ~{1'b0, s_q[i]} + 1'b1;
            end else begin
                s_res[i] = {1'b0, s_q[i]};
            end
        end
    end

    assign o_valid       = dv_valid[QW];
    assign o_out_x       = s_res[0];
    assign o_out_y       = s_res[1];
    assign o_out_z       = s_res[2];
    assign o_zero_length = dv_zero[QW];

    `V3N_ASSERT_IMP(a_zero_out, i_clk, i_rst_n, o_valid && o_zero_length, o_out_x == '0 && o_out_y == '0 && o_out_z == '0)
    `V3N_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `V3N_ASSERT_NXT(a_reset_empty, i_clk, !i_rst_n, !o_valid)
endmodule

// ----- bench/vector3_normalize_tb.sv -----
module vector3_normalize_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW  = v3n_pkg::IN_WIDTH_DEF;
    localparam int OFB = v3n_pkg::OUT_FRAC_BITS_DEF;
    localparam int OW  = OFB + 2;
    localparam int PIPE_DEPTH = IW + OFB + 4;

    typedef struct {
        logic [OW-1:0] nx;
        logic [OW-1:0] ny;
        logic [OW-1:0] nz;
        logic          zlen;
    } t_unit_vec;

    // keeps the normalised vectors still owed by the block, oldest first
    class t_unit_vec_board;
        t_unit_vec owed[$];
        int        errors;
        int        matched;
        int        zero_seen;

        function automatic longint unsigned floor_root(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function automatic t_unit_vec normalise(logic [IW-1:0] x, logic [IW-1:0] y,
                                                logic [IW-1:0] z);
            t_unit_vec       r;
            logic [IW-1:0]   c[3];
            longint unsigned mag[3];
            bit              neg[3];
            longint unsigned sum;
            longint unsigned len;
            longint unsigned q;
            logic [OW-1:0]   o[3];
            c[0] = x; c[1] = y; c[2] = z;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = c[i][IW-1];
                mag[i] = neg[i] ? ((64'd1 << IW) - longint'(c[i])) : longint'(c[i]);
                sum = sum + mag[i] * mag[i];
            end
            len = floor_root(sum);
            if (len == 0) begin
                r.nx = '0; r.ny = '0; r.nz = '0; r.zlen = 1'b1;
                return r;
            end
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] << OFB) / len;
                if (q > (64'd1 << OFB)) q = 64'd1 << OFB;
                if (neg[i]) q = 64'd0 - q;
                o[i] = q[OW-1:0];
            end
            r.nx = o[0]; r.ny = o[1]; r.nz = o[2]; r.zlen = 1'b0;
            return r;
        endfunction

        function void note_request(logic [IW-1:0] x, logic [IW-1:0] y, logic [IW-1:0] z);
            owed.push_back(normalise(x, y, z));
        endfunction

        function void check_result(t_unit_vec got);
            t_unit_vec want;
            if (owed.size() == 0) begin
                $display("%0t: result with nothing owed: %h %h %h %b", $realtime,
                         got.nx, got.ny, got.nz, got.zlen);
                errors++;
                return;
            end
            want = owed.pop_front();
            matched++;
            if (want.zlen) zero_seen++;
            if (got.nx !== want.nx) begin
                $display("%0t: out_x expected %h got %h", $realtime, want.nx, got.nx);
                errors++;
            end
            if (got.ny !== want.ny) begin
                $display("%0t: out_y expected %h got %h", $realtime, want.ny, got.ny);
                errors++;
            end
            if (got.nz !== want.nz) begin
                $display("%0t: out_z expected %h got %h", $realtime, want.nz, got.nz);
                errors++;
            end
            if (got.zlen !== want.zlen) begin
                $display("%0t: zero_length expected %b got %b", $realtime,
                         want.zlen, got.zlen);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [IW-1:0] i_in_x = '0;
    logic [IW-1:0] i_in_y = '0;
    logic [IW-1:0] i_in_z = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [OW-1:0] o_out_x;
    logic [OW-1:0] o_out_y;
    logic [OW-1:0] o_out_z;
    logic          o_zero_length;

    t_unit_vec_board board = new;
    int idle_pct  = 0;
    int stall_pct = 0;
    int holdoff   = 0;

    vector3_normalize DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_in_x(i_in_x), .i_in_y(i_in_y), .i_in_z(i_in_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_zero_length(o_zero_length)
    );

    always #5 i_clk = ~i_clk;

    // receiver side: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (holdoff > 0) begin
            i_stall <= 1'b1;
            holdoff = holdoff - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_unit_vec got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.nx = o_out_x; got.ny = o_out_y; got.nz = o_out_z;
            got.zlen = o_zero_length;
            board.check_result(got);
        end
    end

    // offer one request and hold it until taken
    task automatic send_vec(logic [IW-1:0] x, logic [IW-1:0] y, logic [IW-1:0] z);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_x  <= x;
        i_in_y  <= y;
        i_in_z  <= z;
        do @(posedge i_clk); while (o_stall);
        board.note_request(x, y, z);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge i_clk);
    endtask

    // component mix: full range, small, extremes, zero
    function automatic logic [IW-1:0] rand_comp();
        case ($urandom_range(7))
            0, 1, 2: return $urandom;
            3:       return IW'($signed($urandom_range(0, 4000)) - 2000);
            4:       return $urandom >> $urandom_range(0, 31);
            5:       return {1'b1, {(IW-1){1'b0}}};
            6:       return {1'b0, {(IW-1){1'b1}}};
            default: return '0;
        endcase
    endfunction

    task automatic random_phase(int n, int ip, int sp);
        logic [IW-1:0] v[3];
        idle_pct  = ip;
        stall_pct = sp;
        for (int k = 0; k < n; k++) begin
            for (int j = 0; j < 3; j++) v[j] = rand_comp();
            // one or two components zeroed now and then
            if ($urandom_range(9) == 0) begin
                v[$urandom_range(2)] = '0;
                v[$urandom_range(2)] = '0;
            end
            send_vec(v[0], v[1], v[2]);
        end
    endtask

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        localparam logic [IW-1:0] MAXP = {1'b0, {(IW-1){1'b1}}};
        localparam logic [IW-1:0] MINN = {1'b1, {(IW-1){1'b0}}};
        localparam logic [IW-1:0] NEG1 = '1;
        int waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero vector, axes, extremes, classic triples
        send_vec('0, '0, '0);
        send_vec(1, 0, 0);
        send_vec(0, NEG1, 0);
        send_vec(0, 0, 1);
        send_vec(MAXP, 0, 0);
        send_vec(0, MINN, 0);
        send_vec(0, 0, MINN);
        send_vec(MINN, MINN, MINN);
        send_vec(MAXP, MAXP, MAXP);
        send_vec(MAXP, MINN, MAXP);
        send_vec(1, 1, 1);
        send_vec(NEG1, NEG1, NEG1);
        send_vec(3, 4, 0);
        send_vec(IW'(-3), 0, IW'(-4));
        send_vec(MAXP, 1, NEG1);
        send_vec(1, MINN, 0);
        send_vec('0, '0, '0);
        send_vec(2, 3, 6);
        send_vec(IW'(-65536), 65536, 0);

        random_phase(250, 0, 0);
        random_phase(250, 49, 0);
        random_phase(250, 0, 49);
        random_phase(200, 8, 8);

        // long receiver hold-off while requests keep coming
        stall_pct = 0;
        idle_pct  = 0;
        holdoff   = 300;
        random_phase(120, 0, 0);

        // sender pauses until everything has come back
        wait_drained();
        random_phase(60, 20, 20);

        wait_drained();
        stall_pct = 0;
        waited = 0;
        while (board.owed.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);

        if (board.owed.size() != 0) begin
            $display("%0t: %0d normalised vectors never arrived", $realtime,
                     board.owed.size());
            board.errors++;
        end
        $display("covered %0d vectors (%0d zero-length) over idle, stall and hold-off phases",
                 board.matched, board.zero_seen);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- vector3_normalize.f -----
+incdir+hw/rtl
hw/rtl/v3n_pkg.sv
hw/rtl/v3n_front.sv
hw/rtl/v3n_sqrt_cell.sv
hw/rtl/v3n_div_cell.sv
hw/rtl/vector3_normalize.sv
bench/vector3_normalize_tb.sv
